FILE: design/xmll_pkg.sv
// Shared types, codes and character helpers for the XML markup lexer.
`default_nettype none
package xmll_pkg;

  localparam int unsigned RESQ_DEPTH = 4;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_SYM   = 4'd1,
    MODE_BANG  = 4'd2,
    MODE_DASH  = 4'd3,
    MODE_COMM  = 4'd4,
    MODE_STR   = 4'd5,
    MODE_TEXT  = 4'd6,
    MODE_ENT   = 4'd7,
    MODE_ESKIP = 4'd8
  } mode_t;

  localparam logic [4:0] TK_INVALID = 5'd0;
  localparam logic [4:0] TK_EOF     = 5'd1;
  localparam logic [4:0] TK_LT      = 5'd2;
  localparam logic [4:0] TK_GT      = 5'd3;
  localparam logic [4:0] TK_QUEST   = 5'd4;
  localparam logic [4:0] TK_SLASH   = 5'd5;
  localparam logic [4:0] TK_EQ      = 5'd6;
  localparam logic [4:0] TK_LPAR    = 5'd7;
  localparam logic [4:0] TK_RPAR    = 5'd8;
  localparam logic [4:0] TK_LBRK    = 5'd9;
  localparam logic [4:0] TK_RBRK    = 5'd10;
  localparam logic [4:0] TK_BAR     = 5'd11;
  localparam logic [4:0] TK_STAR    = 5'd12;
  localparam logic [4:0] TK_PLUS    = 5'd13;
  localparam logic [4:0] TK_COMMA   = 5'd14;
  localparam logic [4:0] TK_SEMI    = 5'd15;
  localparam logic [4:0] TK_PCT     = 5'd16;
  localparam logic [4:0] TK_HASH    = 5'd17;
  localparam logic [4:0] TK_APOS    = 5'd18;
  localparam logic [4:0] TK_EXCLAM  = 5'd19;
  localparam logic [4:0] TK_SYMBOL  = 5'd20;
  localparam logic [4:0] TK_STRING  = 5'd21;
  localparam logic [4:0] TK_COMMENT = 5'd22;
  localparam logic [4:0] TK_TEXT    = 5'd23;

  localparam logic [0:0] KIND_PAYLOAD = 1'b0;
  localparam logic [0:0] KIND_TOKEN   = 1'b1;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EXCL  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LC_L  = 8'h6C;
  localparam logic [7:0] CH_LC_G  = 8'h67;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_P  = 8'h70;

  // entity match progress; ENT_FAIL means the name cannot match
  localparam logic [3:0] ENT_FAIL = 4'd8;
  localparam logic [2:0] ENT_LT   = 3'd2;
  localparam logic [2:0] ENT_GT   = 3'd4;
  localparam logic [2:0] ENT_AMP  = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [4:0] ttype;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } pair_t;

  typedef struct packed {
    mode_t mode;
    logic  tag;
    logic  emit;
    res_t  res;
  } idle_out_t;

  function automatic res_t tok(logic [4:0] t);
    res_t r;
    r.kind  = KIND_TOKEN;
    r.ttype = t;
    r.data  = 8'd0;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic res_t pay(logic [4:0] t, logic [7:0] c);
    res_t r;
    r.kind  = KIND_PAYLOAD;
    r.ttype = t;
    r.data  = c;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_sym_delim(logic [7:0] c);
    return c == CH_EQ || c == CH_SLASH || c == CH_GT || c == CH_QUEST ||
           c == CH_BAR || c == CH_RPAR || c == CH_APOS || c == CH_COMMA ||
           c == CH_SEMI;
  endfunction

  function automatic logic [4:0] punct_code(logic [7:0] c);
    logic [4:0] p;
    unique case (c)
      CH_LT:    p = TK_LT;
      CH_GT:    p = TK_GT;
      CH_QUEST: p = TK_QUEST;
      CH_SLASH: p = TK_SLASH;
      CH_EQ:    p = TK_EQ;
      CH_LPAR:  p = TK_LPAR;
      CH_RPAR:  p = TK_RPAR;
      CH_LBRK:  p = TK_LBRK;
      CH_RBRK:  p = TK_RBRK;
      CH_BAR:   p = TK_BAR;
      CH_STAR:  p = TK_STAR;
      CH_PLUS:  p = TK_PLUS;
      CH_COMMA: p = TK_COMMA;
      CH_SEMI:  p = TK_SEMI;
      CH_PCT:   p = TK_PCT;
      CH_HASH:  p = TK_HASH;
      CH_APOS:  p = TK_APOS;
      default:  p = TK_INVALID;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] entity_next(logic [2:0] p, logic [7:0] c);
    logic [3:0] n;
    unique case (p)
      3'd0: begin
        if (c == CH_LC_L) n = 4'd1;
        else if (c == CH_LC_G) n = 4'd3;
        else if (c == CH_LC_A) n = 4'd5;
        else n = ENT_FAIL;
      end
      3'd1:    n = (c == CH_LC_T) ? 4'd2 : ENT_FAIL;
      3'd3:    n = (c == CH_LC_T) ? 4'd4 : ENT_FAIL;
      3'd5:    n = (c == CH_LC_M) ? 4'd6 : ENT_FAIL;
      3'd6:    n = (c == CH_LC_P) ? 4'd7 : ENT_FAIL;
      default: n = ENT_FAIL;
    endcase
    return n;
  endfunction

  // lex one byte from the between-tokens state; at most one result
  function automatic idle_out_t idle_step(logic [7:0] c, logic end_i, logic tag);
    idle_out_t o;
    logic [4:0] p;
    o.mode = MODE_IDLE;
    o.tag  = tag;
    o.emit = 1'b0;
    o.res  = tok(TK_EOF);
    p      = punct_code(c);
    if (end_i) begin
      o.emit = 1'b1;
    end else if (is_ws(c)) begin
      o.emit = 1'b0;
    end else if (p != TK_INVALID) begin
      if (c == CH_LT) o.tag = 1'b1;
      if (c == CH_GT) o.tag = 1'b0;
      o.emit = 1'b1;
      o.res  = tok(p);
    end else if (c == CH_DQUOT) begin
      o.mode = MODE_STR;
    end else if (tag) begin
      if (is_alnum(c)) begin
        o.mode = MODE_SYM;
        o.emit = 1'b1;
        o.res  = pay(TK_SYMBOL, to_lower(c));
      end else if (c == CH_EXCL) begin
        o.mode = MODE_BANG;
      end else begin
        o.emit = 1'b1;
        o.res  = tok(TK_INVALID);
      end
    end else if (c == CH_AMP) begin
      o.mode = MODE_ENT;
    end else begin
      o.mode = MODE_TEXT;
      o.emit = 1'b1;
      o.res  = pay(TK_TEXT, c);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: design/xmll_core.sv
// Lexer state registers and the per-byte next-state and result logic.
`default_nettype none
module xmll_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step_i,
  input  wire  [7:0]          char_i,
  input  wire                 end_i,
  output xmll_pkg::pair_t     res_o
);

  xmll_pkg::mode_t mode_r, mode_nxt;
  logic            tag_r, tag_nxt;
  logic [2:0]      prog_r, prog_nxt;

  xmll_pkg::idle_out_t id;
  xmll_pkg::pair_t     pr;
  logic [3:0]          np;

  always_comb begin
    mode_nxt = mode_r;
    tag_nxt  = tag_r;
    prog_nxt = prog_r;
    pr.cnt   = 2'd0;
    pr.r0    = xmll_pkg::tok(xmll_pkg::TK_INVALID);
    pr.r1    = xmll_pkg::tok(xmll_pkg::TK_EOF);
    id       = xmll_pkg::idle_step(char_i, end_i, tag_r);
    np       = xmll_pkg::entity_next(prog_r, char_i);
    unique case (mode_r)
      xmll_pkg::MODE_SYM: begin
        prog_nxt = 3'd0;
        if (end_i) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_SYMBOL);
          pr.cnt   = 2'd2;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (xmll_pkg::is_ws(char_i)) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_SYMBOL);
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (xmll_pkg::is_sym_delim(char_i)) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_SYMBOL);
          pr.r1    = id.res;
          pr.cnt   = id.emit ? 2'd2 : 2'd1;
          mode_nxt = id.mode;
          tag_nxt  = id.tag;
        end else if (xmll_pkg::is_alnum(char_i) || char_i == xmll_pkg::CH_DASH ||
                     char_i == xmll_pkg::CH_UNDER) begin
          pr.r0    = xmll_pkg::pay(xmll_pkg::TK_SYMBOL, xmll_pkg::to_lower(char_i));
          pr.cnt   = 2'd1;
        end else begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_INVALID);
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end
      end
      xmll_pkg::MODE_BANG: begin
        prog_nxt = 3'd0;
        if (!end_i && char_i == xmll_pkg::CH_DASH) begin
          mode_nxt = xmll_pkg::MODE_DASH;
        end else begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_EXCLAM);
          pr.r1    = id.res;
          pr.cnt   = id.emit ? 2'd2 : 2'd1;
          mode_nxt = id.mode;
          tag_nxt  = id.tag;
        end
      end
      xmll_pkg::MODE_DASH: begin
        prog_nxt = 3'd0;
        pr.r0    = xmll_pkg::tok(xmll_pkg::TK_INVALID);
        if (end_i) begin
          pr.cnt   = 2'd2;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (char_i == xmll_pkg::CH_DASH) begin
          mode_nxt = xmll_pkg::MODE_COMM;
        end else begin
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end
      end
      xmll_pkg::MODE_COMM: begin
        prog_nxt = 3'd0;
        if (end_i) begin
          pr.cnt   = 2'd2;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (char_i == xmll_pkg::CH_GT) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_COMMENT);
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else begin
          pr.r0    = xmll_pkg::pay(xmll_pkg::TK_COMMENT, char_i);
          pr.cnt   = 2'd1;
        end
      end
      xmll_pkg::MODE_STR: begin
        prog_nxt = 3'd0;
        if (end_i) begin
          pr.cnt   = 2'd2;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (char_i == xmll_pkg::CH_DQUOT) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_STRING);
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (char_i != xmll_pkg::CH_BSL) begin
          pr.r0    = xmll_pkg::pay(xmll_pkg::TK_STRING, char_i);
          pr.cnt   = 2'd1;
        end
      end
      xmll_pkg::MODE_TEXT: begin
        prog_nxt = 3'd0;
        if (end_i) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_EOF);
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
        end else if (char_i == xmll_pkg::CH_LT) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_TEXT);
          pr.r1    = id.res;
          pr.cnt   = id.emit ? 2'd2 : 2'd1;
          mode_nxt = id.mode;
          tag_nxt  = id.tag;
        end else if (char_i == xmll_pkg::CH_AMP) begin
          mode_nxt = xmll_pkg::MODE_ENT;
        end else begin
          pr.r0    = xmll_pkg::pay(xmll_pkg::TK_TEXT, char_i);
          pr.cnt   = 2'd1;
        end
      end
      xmll_pkg::MODE_ENT, xmll_pkg::MODE_ESKIP: begin
        if (end_i) begin
          pr.r0    = xmll_pkg::tok(xmll_pkg::TK_EOF);
          pr.cnt   = 2'd1;
          mode_nxt = xmll_pkg::MODE_IDLE;
          prog_nxt = 3'd0;
        end else if (char_i == xmll_pkg::CH_SEMI) begin
          if (mode_r == xmll_pkg::MODE_ENT) begin
            if (prog_r == xmll_pkg::ENT_LT) begin
              pr.r0  = xmll_pkg::pay(xmll_pkg::TK_TEXT, xmll_pkg::CH_LT);
              pr.cnt = 2'd1;
            end else if (prog_r == xmll_pkg::ENT_GT) begin
              pr.r0  = xmll_pkg::pay(xmll_pkg::TK_TEXT, xmll_pkg::CH_GT);
              pr.cnt = 2'd1;
            end else if (prog_r == xmll_pkg::ENT_AMP) begin
              pr.r0  = xmll_pkg::pay(xmll_pkg::TK_TEXT, xmll_pkg::CH_AMP);
              pr.cnt = 2'd1;
            end
          end
          mode_nxt = xmll_pkg::MODE_TEXT;
          prog_nxt = 3'd0;
        end else if (mode_r == xmll_pkg::MODE_ENT) begin
          if (np == xmll_pkg::ENT_FAIL) begin
            mode_nxt = xmll_pkg::MODE_ESKIP;
            prog_nxt = 3'd0;
          end else begin
            prog_nxt = np[2:0];
          end
        end
      end
      default: begin
        pr.r0    = id.res;
        pr.cnt   = id.emit ? 2'd1 : 2'd0;
        mode_nxt = id.mode;
        tag_nxt  = id.tag;
        prog_nxt = 3'd0;
      end
    endcase
    pr.r0.last = (pr.cnt == 2'd1);
    pr.r1.last = 1'b1;
    res_o      = pr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= xmll_pkg::MODE_IDLE;
      tag_r  <= 1'b0;
      prog_r <= 3'd0;
    end else if (step_i) begin
      mode_r <= mode_nxt;
      tag_r  <= tag_nxt;
      prog_r <= prog_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/xmll_resq.sv
// Result queue: takes up to two results per cycle, hands out one per request.
`default_nettype none
module xmll_resq #(
  parameter int unsigned DEPTH = xmll_pkg::RESQ_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push_i,
  input  wire xmll_pkg::pair_t pair_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output xmll_pkg::res_t      head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);

  xmll_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;
  logic [1:0]     npush;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign out_valid_o = (cnt_r != '0);
  assign head_o      = mem_r[rp_r];
  assign pop         = out_valid_o && out_ready_i;
  assign npush       = push_i ? pair_i.cnt : 2'd0;
  assign wp1         = inc(wp_r);
  assign room2_o     = (DEPTH_W - {1'b0, cnt_r} + (CW + 1)'(pop)) >= (CW + 1)'(2);

  always_comb begin
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    wp_nxt  = wp_r;
    if (npush == 2'd1) wp_nxt = wp1;
    if (npush == 2'd2) wp_nxt = inc(wp1);
    cnt_nxt = cnt_r + CW'(npush) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) mem_r[wp_r] <= pair_i.r0;
    if (npush == 2'd2) mem_r[wp1] <= pair_i.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/xml_markup_lexer.sv
// Top level of the XML markup lexer: input register, lexer core, result queue.
//
//   channel | direction | fields                         | handshake
//   in_     | input     | char_byte, end_of_input        | in_valid / in_ready
//   out_    | output    | result_kind, token_type,       | out_valid / out_ready
//           |           | payload_byte, last_of_run      |
//
// One byte per cycle while the queue has room for two results: a request is
// registered, then lexed and its zero to two results written into the result
// queue at once. Results pass through the input register and the queue.
// A byte giving two results takes two output handshakes to drain.
// Reset (rst_n low, synchronous) returns the lexer to idle outside a tag and
// empties the queue. A stalled output holds the input register once the
// queue lacks room for two results; in_ready then drops.
`default_nettype none
module xml_markup_lexer #(
  parameter int unsigned RESQ_DEPTH = xmll_pkg::RESQ_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_char_byte,
  input  wire         in_end_of_input,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_result_kind,
  output logic [4:0]  out_token_type,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_run
);

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_char_r;
  logic            s1_end_r;
  logic            room2, adv;
  xmll_pkg::pair_t pair;
  xmll_pkg::res_t  head;

  assign adv      = s1_valid_r && room2;
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_byte;
      s1_end_r  <= in_end_of_input;
    end
  end

  xmll_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (adv),
    .char_i (s1_char_r),
    .end_i  (s1_end_r),
    .res_o  (pair)
  );

  xmll_resq #(.DEPTH(RESQ_DEPTH)) u_resq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (adv),
    .pair_i      (pair),
    .room2_o     (room2),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .head_o      (head)
  );

  assign out_result_kind  = head.kind;
  assign out_token_type   = head.ttype;
  assign out_payload_byte = head.data;
  assign out_last_of_run  = head.last;

endmodule
`default_nettype wire

FILE: design/xmll_checker.sv
// Port-level checks for the XML markup lexer, bound to the top level.
`default_nettype none
module xmll_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_result_kind,
  input wire [4:0]  out_token_type,
  input wire [7:0]  out_payload_byte,
  input wire        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_type) &&
    $stable(out_payload_byte) && $stable(out_result_kind) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_token_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_payload_byte == 8'd0)
    else $error("token result carries data");

  a_payload_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |->
      out_token_type == xmll_pkg::TK_SYMBOL || out_token_type == xmll_pkg::TK_STRING ||
      out_token_type == xmll_pkg::TK_COMMENT || out_token_type == xmll_pkg::TK_TEXT)
    else $error("payload byte of a token type without content");

endmodule

bind xml_markup_lexer xmll_checker u_xmll_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_token_type   (out_token_type),
  .out_payload_byte (out_payload_byte),
  .out_last_of_run  (out_last_of_run)
);
`default_nettype wire
